>>> sv/sqlud_pkg.sv
package sqlud_pkg;

    localparam int CHAR_W           = 8;
    localparam int KIND_W           = 2;
    localparam int POS_W            = 12;
    localparam int MAX_LINE_DEFAULT = 4096;

    localparam logic [CHAR_W-1:0] DELIM_RESET = 8'h3B;   // ';'
    localparam logic [CHAR_W-1:0] CH_SQUOTE   = 8'h27;
    localparam logic [CHAR_W-1:0] CH_DQUOTE   = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SLASH    = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_STAR     = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DASH     = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_NL       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_NUL      = 8'h00;

    typedef enum logic [KIND_W-1:0] {
        KIND_CTX  = 2'd0,
        KIND_LINE = 2'd1,
        KIND_END  = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        LX_PLAIN  = 3'd0,
        LX_SINGLE = 3'd1,
        LX_DOUBLE = 3'd2,
        LX_BLOCK  = 3'd3,
        LX_LINE   = 3'd4
    } lex_t;

    // Next lexical state for byte x with lookahead y.
    function automatic lex_t lex_scan(lex_t s, logic [CHAR_W-1:0] x, logic [CHAR_W-1:0] y);
        lex_t r;
        r = s;
        unique case (s)
            LX_PLAIN:
            begin
                if (x == CH_SQUOTE)
                    r = LX_SINGLE;
                else if (x == CH_DQUOTE)
                    r = LX_DOUBLE;
                else if (x == CH_SLASH && y == CH_STAR)
                    r = LX_BLOCK;
                else if (x == CH_DASH && y == CH_DASH)
                    r = LX_LINE;
            end
            LX_SINGLE:
            begin
                if (x == CH_SQUOTE)
                    r = LX_PLAIN;
            end
            LX_DOUBLE:
            begin
                if (x == CH_DQUOTE)
                    r = LX_PLAIN;
            end
            LX_BLOCK:
            begin
                if (x == CH_STAR && y == CH_SLASH)
                    r = LX_PLAIN;
            end
            LX_LINE:
            begin
                if (x == CH_NL)
                    r = LX_PLAIN;
            end
            default:
            begin
                r = LX_PLAIN;
            end
        endcase
        return r;
    endfunction

endpackage

>>> sv/sql_unquoted_delimiter_finder_core.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser = kind, s_tdata = char_code
// m_*       out  m_tvalid/m_tready  m_tuser = found, m_tdata = position
// cfg_*     in   cfg_we             cfg_data = delimiter_char
//
// One character per clock when not stalled; scan state advances at the accepting edge.
// The end-of-line transfer loads the result register, which drives the m_* outputs.
// s_tready drops only while a result is held and m_tready is low.
// Reset (rst_n, asynchronous) clears scan state, the result valid and sets delimiter ';'.
module sql_unquoted_delimiter_finder_core #(
    parameter int MAX_LINE = sqlud_pkg::MAX_LINE_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sqlud_pkg::CHAR_W-1:0]  s_tdata,   // [7:0] char_code
    input  logic [sqlud_pkg::KIND_W-1:0]  s_tuser,   // [1:0] kind
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // [11:0] position, [15:12] zero
    output logic [0:0]                    m_tuser,   // [0] found
    // delimiter register
    input  logic                          cfg_we,
    input  logic [sqlud_pkg::CHAR_W-1:0]  cfg_data
);
    import sqlud_pkg::*;

    // line_index saturates at MAX_LINE + 1
    localparam int LIDX_W = $clog2(MAX_LINE + 2);
    localparam logic [LIDX_W-1:0] LINE_LIMIT = LIDX_W'(MAX_LINE);
    localparam logic [LIDX_W-1:0] LINE_SAT   = LIDX_W'(MAX_LINE + 1);

    // Scan state
    lex_t                lex_reg, lex_next;
    logic [CHAR_W-1:0]   held_char_reg, held_char_next;
    logic                held_valid_reg, held_valid_next;
    logic                held_in_line_reg, held_in_line_next;
    logic [LIDX_W-1:0]   line_index_reg, line_index_next;
    logic                hit_seen_reg, hit_seen_next;
    logic [POS_W-1:0]    hit_index_reg, hit_index_next;
    logic [CHAR_W-1:0]   delim_reg;

    // Result register
    logic                out_valid_reg;
    logic                out_found_reg;
    logic [POS_W-1:0]    out_pos_reg;

    // Datapath
    kind_t               kind_in;
    logic                in_xfer;
    logic                ctx_path;
    logic                line_path;
    logic                end_path;
    logic [CHAR_W-1:0]   look_char;
    logic                revert_line;
    lex_t                lex_scanned;
    logic [LIDX_W-1:0]   held_idx;
    logic                hit_now;
    logic                res_found;
    logic [POS_W-1:0]    res_pos;

    assign kind_in  = kind_t'(s_tuser);
    assign s_tready = !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    // A context byte after line bytes counts as a further line byte.
    assign ctx_path  = (kind_in == KIND_CTX) && !(held_valid_reg && held_in_line_reg);
    assign line_path = !ctx_path && (kind_in == KIND_CTX || kind_in == KIND_LINE);
    assign end_path  = (kind_in == KIND_END);

    // Lookahead is the incoming byte unless the held byte ends the context or the line.
    assign look_char   = (ctx_path || (line_path && held_in_line_reg)) ? s_tdata : CH_NUL;
    // An open line comment at the end of the context falls back to plain.
    assign revert_line = !held_in_line_reg && !ctx_path;
    assign lex_scanned = lex_scan(lex_reg, held_char_reg, look_char);

    // Held line byte carries index line_index - 1 (line_index is at least one here).
    assign held_idx = line_index_reg - LIDX_W'(1);
    assign hit_now  = held_valid_reg && held_in_line_reg && !hit_seen_reg
                      && (lex_reg == LX_PLAIN) && (held_char_reg == delim_reg)
                      && (held_idx < LINE_LIMIT);

    assign res_found = hit_seen_reg || hit_now;
    assign res_pos   = hit_seen_reg ? hit_index_reg
                     : (hit_now ? POS_W'(held_idx) : '0);

    always_comb
    begin
        lex_next          = lex_reg;
        held_char_next    = held_char_reg;
        held_valid_next   = held_valid_reg;
        held_in_line_next = held_in_line_reg;
        line_index_next   = line_index_reg;
        hit_seen_next     = hit_seen_reg;
        hit_index_next    = hit_index_reg;

        if (in_xfer && kind_in != KIND_NONE)
        begin
            if (end_path)
            begin
                // Flush and clear the whole scan
                lex_next          = LX_PLAIN;
                held_char_next    = '0;
                held_valid_next   = 1'b0;
                held_in_line_next = 1'b0;
                line_index_next   = '0;
                hit_seen_next     = 1'b0;
                hit_index_next    = '0;
            end
            else
            begin
                if (held_valid_reg)
                begin
                    if (revert_line && lex_scanned == LX_LINE)
                        lex_next = LX_PLAIN;
                    else
                        lex_next = lex_scanned;
                end
                if (hit_now)
                begin
                    hit_seen_next  = 1'b1;
                    hit_index_next = POS_W'(held_idx);
                end
                held_char_next    = s_tdata;
                held_valid_next   = 1'b1;
                held_in_line_next = line_path;
                if (line_path && line_index_reg < LINE_SAT)
                    line_index_next = line_index_reg + LIDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_reg          <= LX_PLAIN;
            held_char_reg    <= '0;
            held_valid_reg   <= 1'b0;
            held_in_line_reg <= 1'b0;
            line_index_reg   <= '0;
            hit_seen_reg     <= 1'b0;
            hit_index_reg    <= '0;
        end
        else
        begin
            lex_reg          <= lex_next;
            held_char_reg    <= held_char_next;
            held_valid_reg   <= held_valid_next;
            held_in_line_reg <= held_in_line_next;
            line_index_reg   <= line_index_next;
            hit_seen_reg     <= hit_seen_next;
            hit_index_reg    <= hit_index_next;
        end
    end

    // Delimiter register: the user must write it only while idle; not enforced by the block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            delim_reg <= DELIM_RESET;
        else if (cfg_we)
            delim_reg <= cfg_data;
    end

    // Result register: load on the end-of-line transfer, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer && end_path)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && end_path)
        begin
            out_found_reg <= res_found;
            out_pos_reg   <= res_pos;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = out_found_reg;
    assign m_tdata    = {{(16 - POS_W){1'b0}}, out_pos_reg};

`ifndef SYNTHESIS
    // A fresh result only follows an end-of-line transfer
    a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser == KIND_END))
        else $error("result without end-of-line transfer");

    // No delimiter found means position zero
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("nonzero position without a hit");

    // A held line byte always has a held byte behind it
    a_held_line: assert property (@(posedge clk) disable iff (!rst_n)
        held_in_line_reg |-> held_valid_reg)
        else $error("held line flag without held byte");

    // End of line clears the scan
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == KIND_END)
        |=> (!held_valid_reg && !hit_seen_reg && line_index_reg == '0 && lex_reg == LX_PLAIN))
        else $error("scan state not cleared after end of line");
`endif

endmodule

>>> bench/tb_sql_unquoted_delimiter_finder_core.sv
module tb_sql_unquoted_delimiter_finder_core;
    import sqlud_pkg::*;

    localparam int LINE_LIMIT = MAX_LINE_DEFAULT;

    // One character-stream transfer as queued by the stimulus.
    typedef struct packed {
        kind_t             kind;
        logic [CHAR_W-1:0] ch;
    } char_item_t;

    // One line verdict as it should leave the result stream.
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
    } line_hit_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [CHAR_W-1:0]   s_tdata = '0;   // [7:0] char_code
    logic [KIND_W-1:0]   s_tuser = '0;   // [1:0] kind
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [15:0]         m_tdata;        // [11:0] position, [15:12] zero
    logic [0:0]          m_tuser;        // [0] found
    logic                cfg_we = 1'b0;
    logic [CHAR_W-1:0]   cfg_data = '0;

    sql_unquoted_delimiter_finder_core #(
        .MAX_LINE(LINE_LIMIT)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stimulus waiting to be offered, and line verdicts waiting to come out.
    char_item_t queue_chars[$];
    line_hit_t  hits_due[$];

    // Flags raised by the stimulus process, read by driver and monitor.
    logic quiet_tail = 1'b0;     // no idling on either side from here on
    logic rx_long_hold = 1'b0;   // ask the receiver for one long hold-off

    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    int unsigned long_hold_left = 0;
    bit          long_hold_done = 1'b0;

    int unsigned chars_queued = 0;
    int unsigned xfer_cnt = 0;
    int unsigned result_cnt = 0;
    int unsigned hit_cnt = 0;
    int unsigned setting_cnt = 0;
    int unsigned fail_cnt = 0;

    // ------------------------------------------------------------------
    // Scanner shadow: own copy of the delimiter register and scan state.
    // ------------------------------------------------------------------
    logic [CHAR_W-1:0] delim_cfg = DELIM_RESET;
    lex_t              scan_lex = LX_PLAIN;
    logic [CHAR_W-1:0] held_ch = '0;
    bit                held_v = 1'b0;
    bit                held_ln = 1'b0;
    int unsigned       line_idx = 0;
    bit                hit_v = 1'b0;
    logic [POS_W-1:0]  hit_pos = '0;

    // Lexical state after byte x, with y as the one-byte lookahead.
    function automatic lex_t lex_after(lex_t cur, logic [CHAR_W-1:0] x, logic [CHAR_W-1:0] y);
        lex_t nxt;
        nxt = cur;
        case (cur)
            LX_PLAIN:
            begin
                if (x == CH_SQUOTE)
                    nxt = LX_SINGLE;
                else if (x == CH_DQUOTE)
                    nxt = LX_DOUBLE;
                else if (x == CH_SLASH && y == CH_STAR)
                    nxt = LX_BLOCK;
                else if (x == CH_DASH && y == CH_DASH)
                    nxt = LX_LINE;
            end
            LX_SINGLE:
            begin
                if (x == CH_SQUOTE)
                    nxt = LX_PLAIN;
            end
            LX_DOUBLE:
            begin
                if (x == CH_DQUOTE)
                    nxt = LX_PLAIN;
            end
            LX_BLOCK:
            begin
                if (x == CH_STAR && y == CH_SLASH)
                    nxt = LX_PLAIN;
            end
            default:
            begin
                // line comment: the newline ends it and is swallowed
                if (x == CH_NL)
                    nxt = LX_PLAIN;
            end
        endcase
        return nxt;
    endfunction

    // Test one byte against the delimiter (line bytes in plain state only,
    // below the line limit), then advance the lexical state.
    function void scan_char(logic [CHAR_W-1:0] x, logic [CHAR_W-1:0] y, bit in_line,
                            int unsigned idx);
        if (in_line && !hit_v && scan_lex == LX_PLAIN && x == delim_cfg && idx < LINE_LIMIT)
        begin
            hit_v   = 1'b1;
            hit_pos = idx[POS_W-1:0];
        end
        scan_lex = lex_after(scan_lex, x, y);
    endfunction

    // Retire the held byte with lookahead y. A context byte always sees NUL,
    // and a line comment left open by the context falls back to plain.
    function void retire_held(logic [CHAR_W-1:0] y);
        if (held_v)
        begin
            if (held_ln)
                scan_char(held_ch, y, 1'b1, (line_idx > 0) ? line_idx - 1 : 0);
            else
            begin
                scan_char(held_ch, CH_NUL, 1'b0, 0);
                if (scan_lex == LX_LINE)
                    scan_lex = LX_PLAIN;
            end
            held_v = 1'b0;
        end
    endfunction

    // Fold one accepted transfer into the shadow; an end item yields a verdict.
    function void track_char(kind_t k, logic [CHAR_W-1:0] ch);
        line_hit_t verdict;
        case (k)
            KIND_NONE:
            begin
                // ignored entirely
            end
            KIND_END:
            begin
                retire_held(CH_NUL);
                verdict.found = hit_v;
                verdict.pos   = hit_v ? hit_pos : '0;
                hits_due.push_back(verdict);
                scan_lex = LX_PLAIN;
                held_ch  = '0;
                held_v   = 1'b0;
                held_ln  = 1'b0;
                line_idx = 0;
                hit_v    = 1'b0;
                hit_pos  = '0;
            end
            default:
            begin
                if (k == KIND_CTX && !(held_v && held_ln))
                begin
                    // context byte: a held context byte looks ahead at this one
                    if (held_v)
                        scan_char(held_ch, ch, 1'b0, 0);
                    held_ch = ch;
                    held_v  = 1'b1;
                    held_ln = 1'b0;
                end
                else
                begin
                    // line byte, or a context byte arriving after line bytes
                    if (held_v)
                        retire_held(held_ln ? ch : CH_NUL);
                    held_ch = ch;
                    held_v  = 1'b1;
                    held_ln = 1'b1;
                    if (line_idx < LINE_LIMIT + 1)
                        line_idx++;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued characters, hold a stalled transfer, and idle
    // in random bursts. Predict at the edge where a transfer completes.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : char_driver
        char_item_t nxt_item;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                track_char(kind_t'(s_tuser), s_tdata);
                xfer_cnt++;
            end
            // hold the item while the block refuses it
            if (!(s_tvalid && !s_tready))
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (queue_chars.size() > 0)
                begin
                    nxt_item = queue_chars.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt_item.kind;
                    s_tdata  <= nxt_item.ch;
                    if (!quiet_tail && $urandom_range(0, 9) == 0)
                        tx_gap = $urandom_range(1, 13);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result transfer with the oldest verdict due,
    // and throttle m_tready with short bursts plus one long hold-off.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        line_hit_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_gap = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                result_cnt++;
                if (hits_due.size() == 0)
                begin
                    $error("result transfer with no line verdict due: found=%0d position=%0d",
                           m_tuser[0], m_tdata[POS_W-1:0]);
                    fail_cnt++;
                end
                else
                begin
                    want = hits_due.pop_front();
                    if (want.found)
                        hit_cnt++;
                    if (m_tuser[0] !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, m_tuser[0]);
                        fail_cnt++;
                    end
                    if (m_tdata[POS_W-1:0] !== want.pos)
                    begin
                        $error("position: expected %0d, got %0d", want.pos,
                               m_tdata[POS_W-1:0]);
                        fail_cnt++;
                    end
                    if (m_tdata[15:POS_W] !== '0)
                    begin
                        $error("tdata pad: expected 0, got %0h", m_tdata[15:POS_W]);
                        fail_cnt++;
                    end
                end
            end
            if (rx_long_hold && !long_hold_done)
            begin
                long_hold_left = 400;
                long_hold_done = 1'b1;
            end
            if (long_hold_left > 0)
            begin
                long_hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 7) == 0)
                    rx_gap = $urandom_range(1, 13);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_char(kind_t k, logic [CHAR_W-1:0] ch);
        char_item_t it;
        it.kind = k;
        it.ch   = ch;
        queue_chars.push_back(it);
        if (k != KIND_NONE)
            chars_queued++;
    endtask

    task automatic push_str(kind_t k, string txt);
        for (int i = 0; i < txt.len(); i++)
            push_char(k, txt[i]);
    endtask

    // Wait until the block has drained, then allow its result latency.
    task automatic drain_wait();
        do
            @(negedge clk);
        while (queue_chars.size() != 0 || s_tvalid || hits_due.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_delim(logic [CHAR_W-1:0] v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        delim_cfg = v;
        setting_cnt++;
        @(negedge clk);
    endtask

    // One SQL-ish fragment: a letter, a space, a quote, a comment opener or closer,
    // a lone comment character, the current delimiter, a newline or a raw byte.
    task automatic push_piece(kind_t k);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            push_char(k, CHAR_W'(8'h61 + $urandom_range(0, 25)));
        else if (r < 38)
            push_char(k, 8'h20);
        else if (r < 48)
            push_char(k, delim_cfg);
        else if (r < 54)
            push_char(k, CH_SQUOTE);
        else if (r < 59)
            push_char(k, CH_DQUOTE);
        else if (r < 64)
        begin
            push_char(k, CH_SLASH);
            push_char(k, CH_STAR);
        end
        else if (r < 70)
        begin
            push_char(k, CH_STAR);
            push_char(k, CH_SLASH);
        end
        else if (r < 75)
        begin
            push_char(k, CH_DASH);
            push_char(k, CH_DASH);
        end
        else if (r < 80)
            push_char(k, CH_NL);
        else if (r < 86)
        begin
            case ($urandom_range(0, 2))
                0: push_char(k, CH_SLASH);
                1: push_char(k, CH_STAR);
                default: push_char(k, CH_DASH);
            endcase
        end
        else
            push_char(k, CHAR_W'($urandom_range(0, 255)));
    endtask

    // Context, then a line, then the end item; a few are broken on purpose.
    task automatic push_statement();
        int unsigned nctx;
        int unsigned nline;
        nctx  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        nline = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
        for (int i = 0; i < nctx; i++)
            push_piece(KIND_CTX);
        for (int i = 0; i < nline; i++)
        begin
            push_piece(KIND_LINE);
            case ($urandom_range(0, 39))
                0: push_piece(KIND_CTX);                       // late context byte
                1: push_char(KIND_NONE, CHAR_W'($urandom_range(0, 255)));
                default: ;
            endcase
        end
        // drop the end item now and then so two statements run together
        if ($urandom_range(0, 19) != 0)
            push_char(KIND_END, CHAR_W'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Sequence: directed cases, then random phases, each under its own
    // delimiter.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [CHAR_W-1:0] phase_delim[6];
        int unsigned       budget;
        phase_delim[0] = 8'hFF;
        phase_delim[1] = 8'h01;
        phase_delim[2] = DELIM_RESET;
        phase_delim[3] = CHAR_W'($urandom_range(1, 255));
        phase_delim[4] = CHAR_W'($urandom_range(1, 255));
        phase_delim[5] = DELIM_RESET;

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, under the reset delimiter.
        push_char(KIND_END, 8'hFF);                          // empty context and line
        push_str(KIND_CTX, "--");                            // comment open at context end
        push_str(KIND_LINE, ";");
        push_char(KIND_END, CH_NUL);
        push_str(KIND_LINE, "/*/");                          // closes its own comment
        push_char(KIND_NONE, DELIM_RESET);                   // ignored kind
        push_str(KIND_LINE, ";");
        push_char(KIND_END, CH_NUL);
        push_str(KIND_LINE, "a");
        push_str(KIND_CTX, ";");                             // context after line bytes
        push_char(KIND_END, CH_NUL);
        push_str(KIND_LINE, "';'--;\n;");                    // quote, line comment, newline
        push_char(KIND_END, CH_NUL);
        drain_wait();

        // NUL as the delimiter: data NUL matches, the end item never does.
        write_delim(CH_NUL);
        push_char(KIND_LINE, 8'hFF);
        push_char(KIND_LINE, CH_NUL);
        push_char(KIND_END, CH_NUL);
        push_str(KIND_LINE, "a");
        push_char(KIND_END, CH_NUL);

        // Random phases. The second one gets the long receiver hold-off;
        // the last one runs with no idling at all.
        budget = chars_queued;
        for (int ph = 0; ph < 6; ph++)
        begin
            drain_wait();
            write_delim(phase_delim[ph]);
            if (ph == 1)
                rx_long_hold <= 1'b1;
            if (ph == 5)
                quiet_tail <= 1'b1;
            budget = budget + 325;
            while (chars_queued < budget)
                push_statement();
            push_char(KIND_END, CHAR_W'($urandom_range(0, 255)));
        end

        drain_wait();
        repeat (8) @(negedge clk);
        if (hits_due.size() != 0)
        begin
            $error("%0d line verdicts never came out", hits_due.size());
            fail_cnt++;
        end
        $display("Scanned %0d character transfers under %0d delimiter settings.",
                 xfer_cnt, setting_cnt + 1);
        $display("Checked %0d line verdicts, %0d of them with an unquoted delimiter.",
                 result_cnt, hit_cnt);
        if (fail_cnt == 0)
            $display("[sql_unquoted_delimiter_finder_core] OK");
        else
            $display("[sql_unquoted_delimiter_finder_core] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5000000;
        $display("[sql_unquoted_delimiter_finder_core] ERROR");
        $finish;
    end

endmodule
